// File: src/exa_pkg.sv
// Package for the float32 exponential pipeline: float constants, the raw
// (unrounded) float record and the multiply, add and round functions.
// Depends on nothing; every module of the block but exa_dly imports it.
`default_nettype none
package exa_pkg;

	// Latency in register stages from an accepted item to its result.
	localparam int unsigned LAT = 20;

	localparam logic [31:0] F_HI_LIMIT = 32'h42B0_0000; // 88.0
	localparam logic [30:0] F_LO_MAG   = 31'h42A0_0000; // magnitude of -80.0
	localparam logic [31:0] F_POS_INF  = 32'h7F80_0000;
	localparam logic [31:0] F_QUIET    = 32'h0040_0000;
	localparam logic [31:0] F_LN2      = 32'h3F31_7218;
	localparam logic [31:0] F_INV_LN2  = 32'h3FB8_AA3B;
	localparam logic [31:0] F_C3       = 32'h3E2A_AAAB;
	localparam logic [31:0] F_C4       = 32'h3D2A_AAAB;
	localparam logic [31:0] F_C5       = 32'h3C08_8889;
	localparam logic [31:0] F_HALF     = 32'h3F00_0000;
	localparam logic [31:0] F_ONE      = 32'h3F80_0000;
	localparam logic [7:0]  EXP_BIAS   = 8'd127;

	// Unrounded result: value = s * 2^(e - 174).
	typedef struct packed {
		logic               sign;
		logic signed [11:0] e;
		logic [49:0]        s;
	} fp_raw_t;

	function automatic logic [5:0] lzc50(input logic [49:0] v);
		logic [5:0] n;
		n = 6'd50;
		for (int i = 0; i < 50; i++) begin
			if (v[i]) n = 6'(49 - i);
		end
		return n;
	endfunction

	function automatic fp_raw_t fmul_raw(input logic [31:0] a, input logic [31:0] b);
		logic [7:0]  ea, eb;
		logic [23:0] ma, mb;
		fp_raw_t     r;
		ea = (a[30:23] == 8'd0) ? 8'd1 : a[30:23];
		eb = (b[30:23] == 8'd0) ? 8'd1 : b[30:23];
		ma = {|a[30:23], a[22:0]};
		mb = {|b[30:23], b[22:0]};
		r.sign = a[31] ^ b[31];
		r.e    = $signed({4'd0, ea}) + $signed({4'd0, eb}) - 12'sd126;
		r.s    = {2'b00, 48'(ma) * 48'(mb)};
		return r;
	endfunction

	function automatic fp_raw_t fadd_raw(input logic [31:0] a, input logic [31:0] b);
		logic [31:0] big, sml;
		logic [7:0]  eb, es, d;
		logic [6:0]  dcap;
		logic [23:0] mb, ms;
		logic [95:0] t;
		logic [49:0] bs, ss, s;
		logic        st, sub;
		fp_raw_t     r;
		if (a[30:0] >= b[30:0]) begin
			big = a;
			sml = b;
		end else begin
			big = b;
			sml = a;
		end
		eb   = (big[30:23] == 8'd0) ? 8'd1 : big[30:23];
		es   = (sml[30:23] == 8'd0) ? 8'd1 : sml[30:23];
		mb   = {|big[30:23], big[22:0]};
		ms   = {|sml[30:23], sml[22:0]};
		d    = eb - es;
		dcap = (d > 8'd72) ? 7'd72 : d[6:0];
		t    = {ms, 72'd0} >> dcap;
		st   = |t[47:0];
		bs   = {2'b00, mb, 24'd0};
		// Bits shifted out are jammed into the lowest bit.
		ss   = {2'b00, t[95:49], t[48] | st};
		sub  = a[31] ^ b[31];
		s    = sub ? (bs - ss) : (bs + ss);
		r.s    = s;
		r.e    = $signed({4'd0, eb});
		r.sign = (s == 50'd0 && sub) ? 1'b0 : big[31];
		return r;
	endfunction

	// Normalise and round to nearest even, with subnormal results.
	function automatic logic [31:0] fround(input fp_raw_t r);
		logic [5:0]         lz;
		logic signed [11:0] en, rs;
		logic [49:0]        sh;
		logic [99:0]        wide;
		logic [7:0]         ef;
		logic               st, rnd, inf;
		logic [30:0]        mag;
		lz   = lzc50(r.s);
		en   = r.e + 12'sd2 - $signed({6'd0, lz});
		rs   = -(r.e + 12'sd1);
		st   = 1'b0;
		inf  = 1'b0;
		ef   = 8'd0;
		wide = {r.s, 50'd0};
		if (en >= 12'sd255) begin
			inf = 1'b1;
			sh  = 50'd0;
		end else if (en >= 12'sd1) begin
			sh = r.s << lz;
			ef = en[7:0];
		end else if (r.e >= -12'sd1) begin
			sh = r.s << 6'(r.e + 12'sd1);
		end else if (rs > 12'sd50) begin
			sh = 50'd0;
			st = |r.s;
		end else begin
			wide = wide >> rs[5:0];
			sh   = wide[99:50];
			st   = |wide[49:0];
		end
		rnd = sh[25] & (st | (|sh[24:0]) | sh[26]);
		mag = {ef, sh[48:26]} + {30'd0, rnd};
		if (r.s == 50'd0) return {r.sign, 31'd0};
		if (inf) return {r.sign, F_POS_INF[30:0]};
		return {r.sign, mag};
	endfunction

endpackage
`default_nettype wire

// File: src/float32_exp_approx.sv
// Approximate float32 exponential: twenty-stage pipeline.
// The item arrives on s_tdata (arg_bits) and leaves on m_tdata (exp_bits).
// One item may be accepted in every cycle unless m_tready holds a result back and freezes the pipeline.
// The datapath is a chain of two-stage float multipliers and adders, each
// rounding to nearest even, which sets the latency: x/ln2, rounding of k,
// k*ln2, the reduction r = x - k*ln2, then the Estrin evaluation of the
// fifth-order polynomial (three product levels and three sum levels), and a
// final stage that scales by 2^k and substitutes the NaN, +Inf and zero
// results that were decided at the input.
// All stages move together under one enable: when the receiver holds
// m_tready low while a result is offered, the whole pipeline freezes and
// s_tready falls, so no item is lost or repeated. Bubbles travel as cleared
// valid bits, so a full pipeline keeps streaming when tready stays high.
// Reset clears every valid bit; no result is offered until new items arrive.
// Depends on exa_pkg and the exa_* submodules.
`default_nettype none
module float32_exp_approx import exa_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [31:0] s_tdata,   // [31:0] arg_bits
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [31:0]      m_tdata    // [31:0] exp_bits
);
	logic [LAT-1:0] vld_q;
	logic           en;

	// The pipeline advances whenever the last stage is empty or being taken.
	assign en       = !vld_q[LAT-1] || m_tready;
	assign s_tready = en;
	assign m_tvalid = vld_q[LAT-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[LAT-2:0], s_tvalid};
		end
	end

	// Arguments decided at the input: NaN made quiet, beyond +88 to +Inf,
	// beyond -80 to zero. Infinities fall into the latter two cases.
	logic        spec;
	logic [31:0] spec_val;

	always_comb begin
		spec     = 1'b1;
		spec_val = 32'd0;
		if (s_tdata[30:23] == 8'hFF && s_tdata[22:0] != 23'd0) begin
			spec_val = s_tdata | F_QUIET;
		end else if (!s_tdata[31] && s_tdata[30:0] > F_HI_LIMIT[30:0]) begin
			spec_val = F_POS_INF;
		end else if (s_tdata[31] && s_tdata[30:0] > F_LO_MAG) begin
			spec_val = 32'd0;
		end else begin
			spec = 1'b0;
		end
	end

	logic [32:0] spec_d;
	exa_dly #(.W(33), .N(LAT-1)) u_spec_dly (
		.clk(clk), .en(en), .d({spec, spec_val}), .q(spec_d));

	// Range reduction: y = x/ln2, k = round(y), r = x - k*ln2.
	logic [31:0] y, kf, kl, x_d, r;
	logic signed [8:0] k;
	logic [8:0] k_d;

	exa_fmul u_mul_y (.clk(clk), .en(en), .a(s_tdata), .b(F_INV_LN2), .y(y));
	exa_kred u_kred (.clk(clk), .en(en), .y(y), .k(k), .kf(kf));
	exa_fmul u_mul_kl (.clk(clk), .en(en), .a(kf), .b(F_LN2), .y(kl));
	exa_dly #(.W(32), .N(5)) u_x_dly (.clk(clk), .en(en), .d(s_tdata), .q(x_d));
	exa_fadd u_add_r (.clk(clk), .en(en), .a(x_d), .b({~kl[31], kl[30:0]}), .y(r));
	exa_dly #(.W(9), .N(16)) u_k_dly (.clk(clk), .en(en), .d(k), .q(k_d));

	// Estrin scheme: ((c5*r + c4)*r^2 + (c3*r + 0.5))*r^2 + (r + 1).
	logic [31:0] r2, a, b, lin, t1, t2, r2_d, t2_d, c, t3, r2_dd, d, lin_d, e;

	exa_fmul u_mul_r2 (.clk(clk), .en(en), .a(r), .b(r), .y(r2));
	exa_fmul u_mul_a (.clk(clk), .en(en), .a(F_C5), .b(r), .y(a));
	exa_fmul u_mul_b (.clk(clk), .en(en), .a(F_C3), .b(r), .y(b));
	exa_fadd u_add_lin (.clk(clk), .en(en), .a(r), .b(F_ONE), .y(lin));
	exa_fadd u_add_t1 (.clk(clk), .en(en), .a(a), .b(F_C4), .y(t1));
	exa_fadd u_add_t2 (.clk(clk), .en(en), .a(b), .b(F_HALF), .y(t2));
	exa_dly #(.W(32), .N(2)) u_r2_dly (.clk(clk), .en(en), .d(r2), .q(r2_d));
	exa_fmul u_mul_c (.clk(clk), .en(en), .a(t1), .b(r2_d), .y(c));
	exa_dly #(.W(32), .N(2)) u_t2_dly (.clk(clk), .en(en), .d(t2), .q(t2_d));
	exa_fadd u_add_t3 (.clk(clk), .en(en), .a(c), .b(t2_d), .y(t3));
	exa_dly #(.W(32), .N(4)) u_r2_dly2 (.clk(clk), .en(en), .d(r2_d), .q(r2_dd));
	exa_fmul u_mul_d (.clk(clk), .en(en), .a(t3), .b(r2_dd), .y(d));
	exa_dly #(.W(32), .N(8)) u_lin_dly (.clk(clk), .en(en), .d(lin), .q(lin_d));
	exa_fadd u_add_e (.clk(clk), .en(en), .a(d), .b(lin_d), .y(e));

	// Scaling by 2^k and the output register.
	exa_scale u_scale (
		.clk(clk), .en(en), .poly(e), .k($signed(k_d)),
		.spec(spec_d[32]), .spec_val(spec_d[31:0]), .res(m_tdata));
endmodule
`default_nettype wire

// File: src/exa_dly.sv
// Delay line that carries side data alongside the arithmetic stages.
// Depends on nothing but the stage enable of the top level.
`default_nettype none
module exa_dly #(
	parameter int unsigned W = 32,
	parameter int unsigned N = 2
) (
	input  wire logic         clk,
	input  wire logic         en,
	input  wire logic [W-1:0] d,
	output logic [W-1:0]      q
);
	logic [W-1:0] dly_q [N];

	always_ff @(posedge clk) begin
		if (en) begin
			dly_q[0] <= d;
			for (int i = 1; i < N; i++) dly_q[i] <= dly_q[i-1];
		end
	end

	assign q = dly_q[N-1];
endmodule
`default_nettype wire

// File: src/exa_fmul.sv
// Two-stage float32 multiplier: product in the first stage, rounding in the second.
// Depends on exa_pkg.
`default_nettype none
module exa_fmul import exa_pkg::*; (
	input  wire logic        clk,
	input  wire logic        en,
	input  wire logic [31:0] a,
	input  wire logic [31:0] b,
	output logic [31:0]      y
);
	fp_raw_t     raw_s1;
	logic [31:0] y_s2;

	always_ff @(posedge clk) begin
		if (en) begin
			raw_s1 <= fmul_raw(a, b);
			y_s2   <= fround(raw_s1);
		end
	end

	assign y = y_s2;
endmodule
`default_nettype wire

// File: src/exa_fadd.sv
// Two-stage float32 adder: alignment and sum first, rounding second.
// Depends on exa_pkg.
`default_nettype none
module exa_fadd import exa_pkg::*; (
	input  wire logic        clk,
	input  wire logic        en,
	input  wire logic [31:0] a,
	input  wire logic [31:0] b,
	output logic [31:0]      y
);
	fp_raw_t     raw_s1;
	logic [31:0] y_s2;

	always_ff @(posedge clk) begin
		if (en) begin
			raw_s1 <= fadd_raw(a, b);
			y_s2   <= fround(raw_s1);
		end
	end

	assign y = y_s2;
endmodule
`default_nettype wire

// File: src/exa_kred.sv
// Range reduction step: rounds x/ln2 half away from zero to k and converts k to float.
// Depends on exa_pkg.
`default_nettype none
module exa_kred import exa_pkg::*; (
	input  wire logic              clk,
	input  wire logic              en,
	input  wire logic [31:0]       y,
	output logic signed [8:0]      k,
	output logic [31:0]            kf
);
	logic [23:0] m;
	logic [7:0]  shamt;
	logic [23:0] q;
	logic [8:0]  kmag;
	logic [3:0]  lz;
	logic [7:0]  norm;
	logic [31:0] kf_c;
	logic signed [8:0] k_c;
	logic signed [8:0] k_s1;
	logic [31:0] kf_s1;

	always_comb begin
		m     = {|y[30:23], y[22:0]};
		shamt = 8'd149 - y[30:23];
		// q is twice the magnitude, truncated.
		q     = (y[30:23] < 8'd126) ? 24'd0 : (m >> shamt[4:0]);
		kmag  = 9'((q[8:0] + 9'd1) >> 1);
		k_c   = y[31] ? -$signed(kmag) : $signed(kmag);
		lz    = 4'd8;
		for (int i = 0; i < 8; i++) begin
			if (kmag[i]) lz = 4'(7 - i);
		end
		norm  = kmag[7:0] << lz[2:0];
		if (kmag == 9'd0) kf_c = 32'd0;
		else kf_c = {y[31], 8'(EXP_BIAS + 8'd7 - {4'd0, lz}), norm[6:0], 16'd0};
	end

	always_ff @(posedge clk) begin
		if (en) begin
			k_s1  <= k_c;
			kf_s1 <= kf_c;
		end
	end

	assign k  = k_s1;
	assign kf = kf_s1;
endmodule
`default_nettype wire

// File: src/exa_scale.sv
// Final stage: scales the polynomial by 2^k in the exponent field and merges
// the results decided at the input (NaN, overflow, underflow). Depends on exa_pkg.
`default_nettype none
module exa_scale import exa_pkg::*; (
	input  wire logic              clk,
	input  wire logic              en,
	input  wire logic [31:0]       poly,
	input  wire logic signed [8:0] k,
	input  wire logic              spec,
	input  wire logic [31:0]       spec_val,
	output logic [31:0]            res
);
	logic [4:0]         n;
	logic [23:0]        man;
	logic [7:0]         exf;
	logic signed [10:0] e;
	logic [31:0]        res_c;
	logic [31:0]        res_s1;

	always_comb begin
		n = 5'd0;
		if (poly[30:23] == 8'd0) begin
			n = 5'd24;
			for (int i = 0; i < 24; i++) begin
				if (poly[i]) n = 5'(23 - i);
			end
		end
		man = {1'b0, poly[22:0]} << n;
		exf = (poly[30:23] == 8'd0) ? 8'd1 : poly[30:23];
		e   = $signed({3'd0, exf}) - 11'sd127 + 11'(k) - $signed({6'd0, n});
		if (spec) res_c = spec_val;
		else if (poly[30:0] == 31'd0) res_c = 32'd0;
		else if (poly[30:23] == 8'hFF) res_c = poly;
		else if (e >= 11'sd128) res_c = F_POS_INF;
		else if (e <= -11'sd127) res_c = 32'd0;
		else res_c = {poly[31], 8'(e + 11'sd127), man[22:0]};
	end

	always_ff @(posedge clk) begin
		if (en) res_s1 <= res_c;
	end

	assign res = res_s1;
endmodule
`default_nettype wire
